// ===== hdl/bmpdec_pkg.sv =====
// bmpdec_pkg: shared constants, register and mode codes, and the issue record
// passed from the frame controller to the emit stage of the bitmap decoder.
// No dependencies.
package bmpdec_pkg;

	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int COLOR_W    = 24;
	localparam int COORD_W    = 12;
	localparam int COL_W      = 13;
	localparam int ROW_W      = 12;
	localparam int RBC_W      = 14;
	localparam int BYTE_W     = 8;
	localparam int NIB_W      = 4;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int PALETTE_DEPTH_DEF = 256;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE   = 2'd2;

	// pixel modes
	localparam logic [1:0] MODE_NIB = 2'd0;
	localparam logic [1:0] MODE_IDX = 2'd1;
	localparam logic [1:0] MODE_RGB = 2'd2;

	// input actions
	localparam logic ACT_PIXEL   = 1'b0;
	localparam logic ACT_PALETTE = 1'b1;

	// byte phases of true-colour mode
	localparam logic [1:0] PH_BLUE  = 2'd0;
	localparam logic [1:0] PH_GREEN = 2'd1;
	localparam logic [1:0] PH_RED   = 2'd2;

	typedef struct packed {
		logic               emit;
		logic               two;
		logic               direct;
		logic               hit0;
		logic               frame_end;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] rgb;
	} issue_t;

endpackage

// ===== hdl/bmpdec_ram.sv =====
// bmpdec_ram: generic synchronous RAM, one write port and two read ports,
// registered read data. No dependencies.
module bmpdec_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== hdl/bmpdec_frame_ctl.sv =====
// bmpdec_frame_ctl: configuration registers and frame position counters;
// decodes each accepted pixel byte into an issue record and palette indices.
// Depends on bmpdec_pkg.
module bmpdec_frame_ctl
	import bmpdec_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_fire,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 data_fire,
	input  logic [BYTE_W-1:0]    data_byte,
	output issue_t               issue,
	output logic [BYTE_W-1:0]    idx_a,
	output logic [NIB_W-1:0]     idx_b
);

	logic [COL_W-1:0] w_q, h_q;
	logic [1:0]       mode_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [RBC_W-1:0] rbc_q;
	logic [1:0]       phase_q;
	logic [15:0]      held_q;
	logic             started_q, done_q;

	logic [COL_W-1:0] col, col_plus1, col_new;
	logic [ROW_W-1:0] row;
	logic [RBC_W-1:0] rbc, rbc_new, row_bytes, padded;
	logic [1:0]       phase, phase_new;
	logic [15:0]      held, held_new;
	logic             in_range, row_done, last_row, emit, two, direct;
	logic [COLOR_W-1:0] rgb;
	logic             step;

	function automatic logic [COL_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
		logic [COL_W-1:0] r;
		r = COL_W'(v);
		if (v == '0) begin
			r = COL_W'(1);
		end else if (32'(v) > maxv) begin
			r = COL_W'(maxv);
		end
		return r;
	endfunction

	// a new frame starts from the top row at column zero
	assign col   = started_q ? col_q : '0;
	assign row   = started_q ? row_q : ROW_W'(h_q - COL_W'(1));
	assign rbc   = started_q ? rbc_q : '0;
	assign phase = started_q ? phase_q : PH_BLUE;
	assign held  = held_q;

	always_comb begin
		unique case (mode_q)
			MODE_NIB: row_bytes = RBC_W'(({1'b0, w_q} + 14'd1) >> 1);
			MODE_IDX: row_bytes = RBC_W'(w_q);
			default:  row_bytes = RBC_W'({w_q, 1'b0}) + RBC_W'(w_q);
		endcase
		padded = (row_bytes + RBC_W'(3)) & ~RBC_W'(3);
	end

	assign col_plus1 = col + COL_W'(1);
	assign in_range  = col < w_q;

	always_comb begin
		emit      = 1'b0;
		two       = 1'b0;
		direct    = 1'b0;
		col_new   = col;
		phase_new = phase;
		held_new  = held;
		rgb       = {data_byte, held};
		if (in_range) begin
			unique case (mode_q)
				MODE_NIB: begin
					emit = 1'b1;
					if (col_plus1 < w_q) begin
						two     = 1'b1;
						col_new = col + COL_W'(2);
					end else begin
						col_new = col_plus1;
					end
				end
				MODE_IDX: begin
					emit    = 1'b1;
					col_new = col_plus1;
				end
				default: begin
					unique case (phase)
						PH_BLUE: begin
							held_new  = {8'h00, data_byte};
							phase_new = PH_GREEN;
						end
						PH_GREEN: begin
							held_new  = {data_byte, held[7:0]};
							phase_new = PH_RED;
						end
						default: begin
							emit      = 1'b1;
							direct    = 1'b1;
							col_new   = col_plus1;
							phase_new = PH_BLUE;
							held_new  = '0;
						end
					endcase
				end
			endcase
		end
	end

	assign rbc_new  = rbc + RBC_W'(1);
	assign row_done = col_new >= w_q;
	assign last_row = row == '0;
	assign step     = data_fire && !done_q;

	always_comb begin
		issue.emit      = emit && !done_q;
		issue.two       = two;
		issue.direct    = direct;
		issue.hit0      = (mode_q == MODE_IDX) ? (32'(data_byte) < PALETTE_DEPTH) : 1'b1;
		issue.frame_end = row_done && last_row;
		issue.x0        = col[COORD_W-1:0];
		issue.y         = row;
		issue.rgb       = rgb;
		idx_a = (mode_q == MODE_NIB) ? {4'h0, data_byte[7:4]} : data_byte;
		idx_b = data_byte[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= COL_W'(1);
			h_q       <= COL_W'(1);
			mode_q    <= MODE_RGB;
			col_q     <= '0;
			row_q     <= '0;
			rbc_q     <= '0;
			phase_q   <= PH_BLUE;
			held_q    <= '0;
			started_q <= 1'b0;
			done_q    <= 1'b0;
		end else if (cfg_fire && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT
				|| cfg_index == REG_PIXEL_MODE)) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  w_q <= clamp_dim(cfg_data, MAX_WIDTH);
				REG_IMAGE_HEIGHT: h_q <= clamp_dim(cfg_data, MAX_HEIGHT);
				default:          mode_q <= (cfg_data[1:0] == MODE_NIB || cfg_data[1:0] == MODE_IDX)
					? cfg_data[1:0] : MODE_RGB;
			endcase
			// a write to any of the three registers restarts the frame
			col_q     <= '0;
			row_q     <= '0;
			rbc_q     <= '0;
			phase_q   <= PH_BLUE;
			held_q    <= '0;
			started_q <= 1'b0;
			done_q    <= 1'b0;
		end else if (step) begin
			started_q <= 1'b1;
			held_q    <= held_new;
			priority if (row_done && last_row) begin
				done_q  <= 1'b1;
				col_q   <= col_new;
				row_q   <= row;
				rbc_q   <= rbc_new;
				phase_q <= phase_new;
			end else if (row_done && rbc_new >= padded) begin
				row_q   <= row - ROW_W'(1);
				col_q   <= '0;
				rbc_q   <= '0;
				phase_q <= PH_BLUE;
			end else begin
				col_q   <= col_new;
				row_q   <= row;
				rbc_q   <= rbc_new;
				phase_q <= phase_new;
			end
		end
	end

	a_done_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !issue.emit)
		else $error("pixel issued after end of frame");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> col_q <= w_q)
		else $error("column counter beyond image width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> COL_W'(row_q) < h_q)
		else $error("row counter beyond image height");

endmodule

// ===== hdl/bmpdec_emit.sv =====
// bmpdec_emit: holds one decoded byte next to the palette read data and
// sends its one or two pixels through the output register.
// Depends on bmpdec_pkg.
module bmpdec_emit
	import bmpdec_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  issue_t             issue,
	input  logic [COLOR_W-1:0] rd_a,
	input  logic [COLOR_W-1:0] rd_b,
	output logic               can_accept,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COORD_W-1:0] pixel_x,
	output logic [COORD_W-1:0] pixel_y,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               last_of_item,
	output logic               frame_end
);

	issue_t             s1_q;
	logic               s1_valid_q, s1_sel_q;
	logic               out_load, s1_last;
	logic [COLOR_W-1:0] color;
	logic [COORD_W-1:0] x;

	assign out_load   = s1_valid_q && (!out_valid || out_ready);
	assign s1_last    = !s1_q.two || s1_sel_q;
	assign can_accept = !s1_valid_q || (s1_last && out_load);

	always_comb begin
		if (s1_sel_q) begin
			color = rd_b;
			x     = s1_q.x0 + COORD_W'(1);
		end else begin
			color = s1_q.direct ? s1_q.rgb : (s1_q.hit0 ? rd_a : '0);
			x     = s1_q.x0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_sel_q   <= 1'b0;
		end else if (load) begin
			s1_valid_q <= 1'b1;
			s1_sel_q   <= 1'b0;
		end else if (out_load) begin
			if (s1_last) begin
				s1_valid_q <= 1'b0;
			end else begin
				s1_sel_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			s1_q <= issue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_x      <= x;
			pixel_y      <= s1_q.y;
			red          <= color[23:16];
			green        <= color[15:8];
			blue         <= color[7:0];
			last_of_item <= s1_last;
			frame_end    <= s1_last && s1_q.frame_end;
		end
	end

	a_sel_two: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_sel_q) |-> s1_q.two)
		else $error("second pixel selected for a one-pixel transaction");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> last_of_item)
		else $error("frame end flagged on a pixel that is not last of its byte");

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_accept)
		else $error("byte loaded while the hold stage is still busy");

endmodule

// ===== hdl/bmp_pixel_stream_decoder_unit.sv =====
// bmp_pixel_stream_decoder_unit: top level of the bitmap pixel-array decoder.
// Depends on bmpdec_pkg, bmpdec_ram, bmpdec_frame_ctl and bmpdec_emit.
//
// Usage:
//   in channel (in_valid/in_ready): action 0 carries one pixel-array byte,
//   action 1 writes palette_color into palette entry palette_index.
//   out channel (out_valid/out_ready): one pixel per transaction with its
//   column, row (bottom-up rows, so rows count down), colour, last_of_item
//   on the last pixel of its byte and frame_end on the final pixel.
//   cfg channel (cfg_valid/cfg_ready): writes image_width, image_height and
//   pixel_mode by index; a write to one of these restarts the frame. cfg_ready is
//   always high; write only while no pixel is in flight.
// A byte waits in the hold stage beside its palette read data; its pixels then
//   enter the output register. Throughput: one byte per cycle in 8-bit and
//   24-bit modes and for palette writes while out_ready is high; a 4-bit byte
//   with two pixels keeps in_ready low as the single output register takes one pixel a cycle.
// The palette is read through both ports of one RAM in the accept cycle.
// Reset clears the counters and registers (width 1, height 1, 24-bit mode);
// the palette content is undefined until written. When out_ready is low the
// output register and the hold stage fill and in_ready drops.
module bmp_pixel_stream_decoder_unit
	import bmpdec_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic [BYTE_W-1:0]    palette_index,
	input  logic [COLOR_W-1:0]   palette_color,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COORD_W-1:0]   pixel_x,
	output logic [COORD_W-1:0]   pixel_y,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue,
	output logic                 last_of_item,
	output logic                 frame_end
);

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	issue_t             issue;
	logic [BYTE_W-1:0]  idx_a;
	logic [NIB_W-1:0]   idx_b;
	logic [COLOR_W-1:0] rd_a, rd_b;
	logic               can_accept, in_fire, data_fire, load, pal_we;

	assign cfg_ready = 1'b1;
	assign in_ready  = can_accept;
	assign in_fire   = in_valid && in_ready;
	assign data_fire = in_fire && (action == ACT_PIXEL);
	assign load      = data_fire && issue.emit;
	// entries beyond the palette depth are not stored
	assign pal_we    = in_fire && (action == ACT_PALETTE)
		&& (32'(palette_index) < PALETTE_DEPTH);

	bmpdec_frame_ctl #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_fire (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.data_fire(data_fire),
		.data_byte(data_byte),
		.issue    (issue),
		.idx_a    (idx_a),
		.idx_b    (idx_b)
	);

	bmpdec_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk    (clk),
		.we     (pal_we),
		.waddr  (AW'(palette_index)),
		.wdata  (palette_color),
		.re     (load),
		.raddr_a(AW'(idx_a)),
		.raddr_b(AW'(idx_b)),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	bmpdec_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.issue       (issue),
		.rd_a        (rd_a),
		.rd_b        (rd_b),
		.can_accept  (can_accept),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last_of_item(last_of_item),
		.frame_end   (frame_end)
	);

endmodule

// ===== sim/bmp_pixel_stream_decoder_unit_tb.sv =====
// testbench for bmp_pixel_stream_decoder_unit: a predictor tracks palette, frame counters and
// byte phases, and checks every pixel against the output stream under random stalls
// depends on bmpdec_pkg and the decoder rtl
module bmp_pixel_stream_decoder_unit_tb;
	import bmpdec_pkg::*;

	// mode code the block folds into true colour
	localparam logic [1:0]           MODE_RGB_ALIAS = 2'd3;
	// register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 2'd3;
	localparam int HOLD_CYCLES  = 150;
	localparam int RANDOM_ITEMS = 300;
	localparam int WIDE_BYTES   = 16;
	localparam int DRAIN_LIMIT  = 20000;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic               last;
		logic               fend;
	} pixel_t;

	typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]     reg_val;
		logic                 act;
		logic [7:0]           b;
		logic [7:0]           pidx;
		logic [COLOR_W-1:0]   pcol;
		bit                   typed;
		pixel_t               want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 action;
	logic [BYTE_W-1:0]    data_byte;
	logic [BYTE_W-1:0]    palette_index;
	logic [COLOR_W-1:0]   palette_color;
	logic                 out_valid;
	logic                 out_ready;
	logic [COORD_W-1:0]   pixel_x;
	logic [COORD_W-1:0]   pixel_y;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;
	logic                 last_of_item;
	logic                 frame_end;

	// directed rows carry a typed pixel alongside the payload
	bit     row_typed;
	pixel_t row_want;

	bit gap_on;
	bit stall_on;
	bit hold_req;

	// predictor state
	logic [CFG_W-1:0]   cfg_width;
	logic [CFG_W-1:0]   cfg_height;
	logic [1:0]         cfg_mode;
	int unsigned        col;
	int unsigned        row;
	int unsigned        bytes_in_row;
	logic [1:0]         phase;
	logic [15:0]        held;
	bit                 frame_started;
	bit                 frame_done;
	logic [COLOR_W-1:0] palette [256];

	pixel_t pixels_due[$];
	pixel_t due;
	int     produced;

	int errors;
	int pixels_checked;
	int frame_ends_seen;
	int transactions_in;
	int reg_writes;
	int setups;

	bmp_pixel_stream_decoder_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.data_byte    (data_byte),
		.palette_index(palette_index),
		.palette_color(palette_color),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.last_of_item (last_of_item),
		.frame_end    (frame_end)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned limit);
		if (v == 0)
			return 1;
		if (v > limit)
			return limit;
		return v;
	endfunction

	// bytes per row including the padding to a multiple of four
	function automatic int unsigned row_pitch(int unsigned w, logic [1:0] m);
		int unsigned rb;
		case (m)
			MODE_NIB: rb = (w + 1) / 2;
			MODE_IDX: rb = w;
			default:  rb = 3 * w;
		endcase
		return (rb + 3) / 4 * 4;
	endfunction

	function automatic void restart_frame();
		col = 0;
		row = 0;
		bytes_in_row = 0;
		phase = PH_BLUE;
		held = '0;
		frame_started = 1'b0;
		frame_done = 1'b0;
	endfunction

	function automatic void emit_pixel(int unsigned x, int unsigned y, logic [COLOR_W-1:0] rgb);
		pixel_t p;
		p.x = COORD_W'(x);
		p.y = COORD_W'(y);
		p.red = rgb[23:16];
		p.green = rgb[15:8];
		p.blue = rgb[7:0];
		p.last = 1'b0;
		p.fend = 1'b0;
		pixels_due.push_back(p);
	endfunction

	// works out the pixels one input transaction causes and queues them
	function automatic int decode_transaction(logic act, logic [7:0] b, logic [7:0] pidx,
			logic [COLOR_W-1:0] pcol);
		int unsigned w;
		int unsigned h;
		int unsigned pitch;
		logic [1:0]  m;
		int          n;
		w = clamp_dim(cfg_width, MAX_WIDTH);
		h = clamp_dim(cfg_height, MAX_HEIGHT);
		m = (cfg_mode == MODE_RGB_ALIAS) ? MODE_RGB : cfg_mode;
		n = 0;
		if (act == ACT_PALETTE) begin
			palette[pidx] = pcol;
			return 0;
		end
		if (frame_done)
			return 0;
		if (!frame_started) begin
			frame_started = 1'b1;
			row = h - 1;
			col = 0;
			bytes_in_row = 0;
			phase = PH_BLUE;
		end
		pitch = row_pitch(w, m);
		if (col < w) begin
			if (m == MODE_NIB) begin
				emit_pixel(col, row, palette[b[7:4]]);
				n++;
				col++;
				// odd width: low nibble of the row's last byte is dropped
				if (col < w) begin
					emit_pixel(col, row, palette[b[3:0]]);
					n++;
					col++;
				end
			end else if (m == MODE_IDX) begin
				emit_pixel(col, row, palette[b]);
				n++;
				col++;
			end else if (phase == PH_BLUE) begin
				held = {8'h00, b};
				phase = PH_GREEN;
			end else if (phase == PH_GREEN) begin
				held[15:8] = b;
				phase = PH_RED;
			end else begin
				emit_pixel(col, row, {b, held[15:8], held[7:0]});
				n++;
				col++;
				phase = PH_BLUE;
				held = '0;
			end
		end
		bytes_in_row++;
		if (n > 0)
			pixels_due[pixels_due.size() - 1].last = 1'b1;
		if (col >= w) begin
			if (row == 0) begin
				if (n > 0)
					pixels_due[pixels_due.size() - 1].fend = 1'b1;
				frame_done = 1'b1;
			end else if (bytes_in_row >= pitch) begin
				row--;
				col = 0;
				bytes_in_row = 0;
				phase = PH_BLUE;
			end
		end
		return n;
	endfunction

	function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic stim_row_t byte_row(logic [7:0] b);
		stim_row_t r;
		r.kind = ROW_ITEM;
		r.reg_idx = REG_IMAGE_WIDTH;
		r.reg_val = '0;
		r.act = ACT_PIXEL;
		r.b = b;
		r.pidx = $urandom_range(0, 255);
		r.pcol = $urandom_range(0, 24'hFFFFFF);
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t byte_row_exp(logic [7:0] b, int unsigned x, int unsigned y,
			logic [COLOR_W-1:0] rgb, logic fend);
		stim_row_t r;
		r = byte_row(b);
		r.typed = 1'b1;
		r.want.x = COORD_W'(x);
		r.want.y = COORD_W'(y);
		r.want.red = rgb[23:16];
		r.want.green = rgb[15:8];
		r.want.blue = rgb[7:0];
		r.want.last = 1'b1;
		r.want.fend = fend;
		return r;
	endfunction

	function automatic stim_row_t pal_row(logic [7:0] idx, logic [COLOR_W-1:0] rgb);
		stim_row_t r;
		r = byte_row($urandom_range(0, 255));
		r.act = ACT_PALETTE;
		r.pidx = idx;
		r.pcol = rgb;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		stim_row_t r;
		r = byte_row(8'h00);
		r.kind = ROW_CFG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	task automatic send_item(logic act, logic [7:0] b, logic [7:0] pidx,
			logic [COLOR_W-1:0] pcol, bit typed, pixel_t want);
		int unsigned g;
		g = gap_on ? pick_gap() : 0;
		cfg_valid <= 1'b0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		data_byte <= b;
		palette_index <= pidx;
		palette_color <= pcol;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		reg_writes++;
	endtask

	// drain all pending pixels, then allow for bytes still in the pipe that make none
	task automatic settle();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// predictor and output checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready && cfg_index != REG_SPARE) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  cfg_width = cfg_data;
					REG_IMAGE_HEIGHT: cfg_height = cfg_data;
					default:          cfg_mode = cfg_data[1:0];
				endcase
				restart_frame();
			end
			if (in_valid && in_ready) begin
				produced = decode_transaction(action, data_byte, palette_index, palette_color);
				if (row_typed && produced == 1)
					pixels_due[pixels_due.size() - 1] = row_want;
				transactions_in++;
			end
			if (out_valid && out_ready) begin
				if (pixels_due.size() == 0) begin
					$error("pixel at (%0d,%0d) with no transaction pending", pixel_x, pixel_y);
					errors++;
				end else begin
					due = pixels_due.pop_front();
					check_field("pixel_x", due.x, pixel_x);
					check_field("pixel_y", due.y, pixel_y);
					check_field("red", due.red, red);
					check_field("green", due.green, green);
					check_field("blue", due.blue, blue);
					check_field("last_of_item", due.last, last_of_item);
					check_field("frame_end", due.fend, frame_end);
					pixels_checked++;
					if (due.fend)
						frame_ends_seen++;
				end
			end
		end
	end

	// receiver: random stalls plus a long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (stall_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("timeout: stream did not complete");
		$display("Some tests failed");
		$finish;
	end

	initial begin
		stim_row_t        plan[$];
		int unsigned      w;
		int unsigned      h;
		int unsigned      pitch;
		int unsigned      total;
		int unsigned      lim;
		int unsigned      len;
		int unsigned      extra;
		int unsigned      body_sent;
		int unsigned      waited;
		int               phase_no;
		int unsigned      r;
		logic [1:0]       mode;
		logic [CFG_W-1:0] wv;
		logic [CFG_W-1:0] hv;
		logic [CFG_W-1:0] mv;
		bit               pressure;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_PIXEL;
		data_byte = '0;
		palette_index = '0;
		palette_color = '0;
		row_typed = 1'b0;
		row_want = '0;
		gap_on = 1'b1;
		stall_on = 1'b1;
		hold_req = 1'b0;
		cfg_width = 1;
		cfg_height = 1;
		cfg_mode = MODE_RGB;
		restart_frame();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole palette so that no lookup hits an unwritten entry
		for (int i = 0; i < 256; i++)
			send_item(ACT_PALETTE, $urandom_range(0, 255), i[7:0],
				$urandom_range(0, 24'hFFFFFF), 1'b0, '0);

		// reset frame is 1x1 true colour, bytes in blue, green, red order
		plan.push_back(byte_row(8'h11));
		plan.push_back(byte_row(8'h22));
		plan.push_back(byte_row_exp(8'h33, 0, 0, 24'h332211, 1'b1));
		plan.push_back(byte_row(8'h44));
		plan.push_back(pal_row(8'h00, 24'h000000));
		plan.push_back(pal_row(8'hFF, 24'hFFFFFF));
		plan.push_back(pal_row(8'h80, 24'hABCDEF));
		// zero width reads as one; rows padded to four bytes
		plan.push_back(cfg_row(REG_PIXEL_MODE, MODE_IDX));
		plan.push_back(cfg_row(REG_IMAGE_WIDTH, 0));
		plan.push_back(cfg_row(REG_IMAGE_HEIGHT, 2));
		plan.push_back(byte_row_exp(8'hFF, 0, 1, 24'hFFFFFF, 1'b0));
		plan.push_back(byte_row(8'h00));
		plan.push_back(byte_row(8'h00));
		plan.push_back(byte_row(8'h00));
		plan.push_back(byte_row_exp(8'h80, 0, 0, 24'hABCDEF, 1'b1));
		// odd width in 4-bit mode
		plan.push_back(cfg_row(REG_PIXEL_MODE, MODE_NIB));
		plan.push_back(cfg_row(REG_IMAGE_WIDTH, 3));
		plan.push_back(byte_row(8'hF0));
		plan.push_back(byte_row_exp(8'h0F, 2, 1, 24'h000000, 1'b0));
		// mode three and a saturated height
		plan.push_back(cfg_row(REG_PIXEL_MODE, MODE_RGB_ALIAS));
		plan.push_back(cfg_row(REG_IMAGE_HEIGHT, 8191));
		plan.push_back(cfg_row(REG_IMAGE_WIDTH, 1));
		plan.push_back(byte_row(8'h01));
		plan.push_back(byte_row(8'h02));
		plan.push_back(byte_row_exp(8'h03, 0, 4095, 24'h030201, 1'b0));

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_CFG) begin
				settle();
				write_reg(plan[k].reg_idx, plan[k].reg_val);
			end else begin
				send_item(plan[k].act, plan[k].b, plan[k].pidx, plan[k].pcol,
					plan[k].typed, plan[k].want);
			end
		end

		// random frames: mostly complete, some cut short, some with trailing bytes
		body_sent = 0;
		phase_no = 0;
		while (body_sent < RANDOM_ITEMS) begin
			pressure = (phase_no % 12 == 0);
			settle();
			setups++;
			if (phase_no == 0)
				write_reg(REG_SPARE, $urandom_range(0, 8191));
			if (pressure) begin
				wv = 16;
				hv = 4;
				mode = MODE_IDX;
			end else begin
				r = $urandom_range(0, 99);
				wv = (r < 5) ? 0 : (r < 12) ? $urandom_range(17, 60) : $urandom_range(1, 9);
				r = $urandom_range(0, 99);
				if (r < 5)
					hv = 0;
				else if (r < 7)
					hv = 4096;
				else if (r < 9)
					hv = 8191;
				else if (r < 11)
					hv = $urandom_range(0, 8191);
				else
					hv = $urandom_range(1, 4);
				mode = $urandom_range(MODE_NIB, MODE_RGB_ALIAS);
			end
			if (!pressure && phase_no > 0 && $urandom_range(0, 3) == 0) begin
				// same settings again: only restarts the frame
				wv = cfg_width;
				hv = cfg_height;
				mode = cfg_mode;
				write_reg(REG_PIXEL_MODE, mode);
			end else begin
				mv = $urandom_range(0, 8191);
				mv[1:0] = mode;
				write_reg(REG_IMAGE_WIDTH, wv);
				write_reg(REG_IMAGE_HEIGHT, hv);
				write_reg(REG_PIXEL_MODE, mv);
			end
			gap_on = !pressure && $urandom_range(0, 3) != 0;
			stall_on = $urandom_range(0, 3) != 0;

			w = clamp_dim(wv, MAX_WIDTH);
			h = clamp_dim(hv, MAX_HEIGHT);
			pitch = row_pitch(w, (mode == MODE_RGB_ALIAS) ? MODE_RGB : mode);
			total = pitch * h;
			if (pressure || (h <= 8 && total <= 400 && $urandom_range(0, 99) < 85)) begin
				len = total;
				extra = $urandom_range(0, 4);
			end else begin
				lim = (total < 3 * pitch) ? total : 3 * pitch;
				len = $urandom_range(1, lim);
				extra = 0;
			end
			for (int k = 0; k < len + extra && body_sent < RANDOM_ITEMS; k++) begin
				if (pressure && k == 4)
					hold_req = 1'b1;
				if ($urandom_range(0, 99) < 8) begin
					send_item(ACT_PALETTE, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 24'hFFFFFF), 1'b0, '0);
					body_sent++;
				end
				send_item(ACT_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 24'hFFFFFF), 1'b0, '0);
				if (k < len)
					body_sent++;
			end
			phase_no++;
		end

		// a short stretch of the top row at the saturated width
		settle();
		setups++;
		write_reg(REG_IMAGE_WIDTH, 8191);
		write_reg(REG_IMAGE_HEIGHT, 2);
		write_reg(REG_PIXEL_MODE, MODE_NIB);
		gap_on = 1'b0;
		stall_on = 1'b1;
		for (int k = 0; k < WIDE_BYTES; k++)
			send_item(ACT_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 24'hFFFFFF), 1'b0, '0);

		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		waited = 0;
		while (pixels_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pixels_due.size() != 0) begin
			$error("%0d expected pixels never arrived", pixels_due.size());
			errors++;
		end

		$display("stream: %0d input transactions, %0d register writes, %0d frame setups",
			transactions_in, reg_writes, setups);
		$display("output: %0d pixels compared, %0d frame ends, all pixel modes under stalls",
			pixels_checked, frame_ends_seen);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
